[src/assert_macros.svh]
// assertion macros for the flow table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/tcpr_pkg.sv]
// types and constants of the tcp retransmission flow table
package tcpr_pkg;

  localparam logic       FUNC_RECORD = 1'b0;
  localparam logic       FUNC_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [14:0] RATE_SCALE = 15'd25600;
  localparam int          PROD_W     = 47;

  typedef struct packed {
    logic        func;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] seq_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_retransmit;
    logic [31:0] pair_total;
    logic [31:0] pair_retransmits;
    logic [14:0] rate_percent_q8;
    logic [4:0]  active_count;
  } out_item_t;

  // data handed from cell to cell
  typedef struct packed {
    logic        found;
    logic        retx;
    logic        free_seen;
    logic [31:0] total;
    logic [31:0] retrans;
  } chain_t;

  // control broadcast to every cell
  typedef struct packed {
    logic rec_en;
    logic hit;
  } cell_ctl_t;

endpackage

[src/tcp_retransmission_flow_table_top.sv]
// top level of the tcp retransmission flow table
// A record registers the item, then matches it across the row of entry
// cells, each cell passing its match, counts and free flag to the next,
// and the out_valid strobe is registered after that match. A query that
// finds its pair goes through the match, one multiply and a restoring
// divider that retires one quotient bit per cycle over 47 bits.
// The result strobe lasts one cycle and cannot be held off; busy is low
// in that cycle, so the next start may coincide with it.
`include "assert_macros.svh"

module tcp_retransmission_flow_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcpr_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tcpr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PW    = tcpr_pkg::PROD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [7:0]          proto_r;
  tcpr_pkg::in_item_t  item_r;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [31:0]         tot_r, rtr_r;
  logic [PW-1:0]       div_r, div_nxt;
  logic [32:0]         rem_r, rem_nxt, rem_sh;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcpr_pkg::out_item_t out_r, out_nxt;
  tcpr_pkg::cell_ctl_t ctl;
  tcpr_pkg::chain_t    chain [TABLE_DEPTH+1];
  logic                hit, any_free, is_tcp, ge;

  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tcpr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .item      (item_r),
      .ctl       (ctl),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  assign hit      = chain[TABLE_DEPTH].found;
  assign any_free = chain[TABLE_DEPTH].free_seen;
  assign is_tcp   = item_r.protocol == proto_r;

  assign rem_sh = {rem_r[31:0], div_r[PW-1]};
  assign ge     = rem_sh >= {1'b0, tot_r};

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctl.rec_en    = 1'b0;
    ctl.hit       = hit;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        out_nxt       = '0;
        out_nxt.active_count = 5'(used_r);
        if (item_r.func == tcpr_pkg::FUNC_RECORD) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (!is_tcp) begin
            out_nxt.status = tcpr_pkg::ST_IGNORED;
          end else if (hit) begin
            ctl.rec_en            = 1'b1;
            out_nxt.status        = tcpr_pkg::ST_OK;
            out_nxt.is_retransmit = chain[TABLE_DEPTH].retx;
          end else if (any_free) begin
            ctl.rec_en           = 1'b1;
            used_nxt             = used_r + CNT_W'(1);
            out_nxt.status       = tcpr_pkg::ST_OK;
            out_nxt.active_count = 5'(used_nxt);
          end else begin
            out_nxt.status = tcpr_pkg::ST_FULL;
          end
        end else if (!hit) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_nxt.status = tcpr_pkg::ST_NOT_FOUND;
        end else begin
          state_nxt                = S_MUL;
          out_nxt.status           = tcpr_pkg::ST_OK;
          out_nxt.pair_total       = chain[TABLE_DEPTH].total;
          out_nxt.pair_retransmits = chain[TABLE_DEPTH].retrans;
        end
      end
      S_MUL: begin
        div_nxt   = PW'(rtr_r) * PW'(tcpr_pkg::RATE_SCALE);
        rem_nxt   = '0;
        cnt_nxt   = 6'(PW - 1);
        state_nxt = (tot_r == 32'd0) ? S_IDLE : S_DIV;
        if (tot_r == 32'd0) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? (rem_sh - {1'b0, tot_r}) : rem_sh;
        div_nxt = {div_r[PW-2:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt.rate_percent_q8 = (div_nxt > PW'(tcpr_pkg::RATE_SCALE)) ?
                                    tcpr_pkg::RATE_SCALE : div_nxt[14:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      proto_r     <= 8'd6;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        proto_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      item_r <= in_item;
    end
    if (state_r == S_LOOK) begin
      tot_r <= chain[TABLE_DEPTH].total;
      rtr_r <= chain[TABLE_DEPTH].retrans;
    end
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_IMPL(a_out_not_busy, out_valid, !busy)
  `ASSERT_IMPL(a_used_bound, 1'b1, used_r <= CNT_W'(TABLE_DEPTH))
  `ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `ASSERT_IMPL(a_nf_zero, out_valid && out_item.status == tcpr_pkg::ST_NOT_FOUND, out_item.pair_total == 32'd0)

endmodule

[src/tcpr_cell.sv]
// one table entry with key match, allocation and counters
module tcpr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tcpr_pkg::in_item_t item,
  input  tcpr_pkg::cell_ctl_t ctl,
  input  tcpr_pkg::chain_t   chain_in,
  output tcpr_pkg::chain_t   chain_out
);

  logic        valid_r, valid_nxt;
  logic [31:0] src_r, dst_r, hseq_r, total_r, retrans_r;
  logic        match, retx, alloc_here, upd_here;

  assign match      = valid_r && (src_r == item.src_addr) && (dst_r == item.dst_addr);
  assign retx       = match && (total_r != 32'd0) && (item.seq_number < hseq_r);
  assign alloc_here = ctl.rec_en && !ctl.hit && !valid_r && !chain_in.free_seen;
  assign upd_here   = ctl.rec_en && match;
  assign valid_nxt  = valid_r || alloc_here;

  always_comb begin
    chain_out.found     = chain_in.found | match;
    chain_out.retx      = chain_in.retx | retx;
    chain_out.free_seen = chain_in.free_seen | !valid_r;
    chain_out.total     = chain_in.total | (match ? total_r : 32'd0);
    chain_out.retrans   = chain_in.retrans | (match ? retrans_r : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_here) begin
      src_r     <= item.src_addr;
      dst_r     <= item.dst_addr;
      hseq_r    <= item.seq_number;
      total_r   <= 32'd1;
      retrans_r <= 32'd0;
    end else if (upd_here) begin
      if (item.seq_number > hseq_r) begin
        hseq_r <= item.seq_number;
      end
      if (total_r != tcpr_pkg::CNT_MAX) begin
        total_r <= total_r + 32'd1;
      end
      if (retx && (retrans_r != tcpr_pkg::CNT_MAX)) begin
        retrans_r <= retrans_r + 32'd1;
      end
    end
  end

endmodule

[test/tb.sv]
// testbench for the tcp retransmission flow table: directed and random items, scoreboard check
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  logic clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready;
  logic [7:0] cfg_data;
  tcpr_pkg::in_item_t in_item;
  tcpr_pkg::out_item_t out_item;

  tcp_retransmission_flow_table_top #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0]  tcp_proto;
  logic        ent_valid [DEPTH];
  logic [31:0] ent_src [DEPTH];
  logic [31:0] ent_dst [DEPTH];
  logic [31:0] ent_high [DEPTH];
  logic [31:0] ent_total [DEPTH];
  logic [31:0] ent_retx [DEPTH];
  logic [4:0]  n_used;

  tcpr_pkg::in_item_t  pending_items[$];
  tcpr_pkg::out_item_t expected_results[$];
  int sender_idle_pct;
  int n_errors;
  logic [31:0] src_pool [8];
  logic [31:0] dst_pool [8];
  logic busy_at_edge;

  function automatic tcpr_pkg::out_item_t flow_table_step(tcpr_pkg::in_item_t it);
    tcpr_pkg::out_item_t r;
    int hit;
    logic [63:0] q;
    hit = -1;
    r = '0;
    r.status = tcpr_pkg::ST_OK;
    for (int i = 0; i < DEPTH; i++)
      if (hit < 0 && ent_valid[i] && ent_src[i] == it.src_addr && ent_dst[i] == it.dst_addr)
        hit = i;
    if (it.func == tcpr_pkg::FUNC_RECORD) begin
      if (it.protocol != tcp_proto) begin
        r.status = tcpr_pkg::ST_IGNORED;
      end else begin
        if (hit < 0) begin
          for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && !ent_valid[i]) begin
              hit = i;
              ent_valid[i] = 1'b1;
              ent_src[i] = it.src_addr;
              ent_dst[i] = it.dst_addr;
              ent_high[i] = it.seq_number;
              ent_total[i] = '0;
              ent_retx[i] = '0;
              n_used++;
            end
        end
        if (hit < 0) begin
          r.status = tcpr_pkg::ST_FULL;
        end else begin
          if (ent_total[hit] != 0 && it.seq_number < ent_high[hit]) begin
            r.is_retransmit = 1'b1;
            if (ent_retx[hit] != tcpr_pkg::CNT_MAX) ent_retx[hit]++;
          end
          if (it.seq_number > ent_high[hit]) ent_high[hit] = it.seq_number;
          if (ent_total[hit] != tcpr_pkg::CNT_MAX) ent_total[hit]++;
        end
      end
    end else if (hit < 0) begin
      r.status = tcpr_pkg::ST_NOT_FOUND;
    end else begin
      r.pair_total = ent_total[hit];
      r.pair_retransmits = ent_retx[hit];
      if (ent_total[hit] != 0) begin
        q = (64'(ent_retx[hit]) * 64'd25600) / 64'(ent_total[hit]);
        r.rate_percent_q8 = (q > 64'd25600) ? tcpr_pkg::RATE_SCALE : q[14:0];
      end
    end
    r.active_count = n_used;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_item <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_items.size() > 0 &&
                 $urandom_range(99) >= sender_idle_pct) begin
      in_item <= pending_items.pop_front();
      start <= 1'b1;
    end
  end

  // acceptance seen at the rising edge
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (rst_n && start && !busy)
      expected_results.push_back(flow_table_step(in_item));
  end

  // monitor
  always @(posedge clk) begin
    tcpr_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", out_item);
      end else begin
        e = expected_results.pop_front();
        if (out_item !== e) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %p, got %p", e, out_item);
        end
      end
    end
  end

  function automatic tcpr_pkg::in_item_t rand_item(bit well_formed);
    tcpr_pkg::in_item_t it;
    int k;
    it.func = ($urandom_range(99) < 30) ? tcpr_pkg::FUNC_QUERY : tcpr_pkg::FUNC_RECORD;
    it.protocol = ($urandom_range(99) < 85 && well_formed) ? tcp_proto : 8'($urandom);
    k = $urandom_range(7);
    it.src_addr = well_formed ? src_pool[k] : $urandom;
    it.dst_addr = well_formed ? dst_pool[$urandom_range(k % 4, k % 4 + 1)] : $urandom;
    it.seq_number = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0)
                                             : $urandom;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_protocol(logic [7:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tcp_proto = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(logic f, logic [7:0] p, logic [31:0] s, logic [31:0] d,
                          logic [31:0] q);
    tcpr_pkg::in_item_t it;
    it.func = f;
    it.protocol = p;
    it.src_addr = s;
    it.dst_addr = d;
    it.seq_number = q;
    pending_items.push_back(it);
  endtask

  initial begin
    n_errors = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sender_idle_pct = 19;
    tcp_proto = 8'd6;
    n_used = '0;
    for (int i = 0; i < DEPTH; i++) ent_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) begin
      src_pool[i] = $urandom;
      dst_pool[i] = $urandom;
    end
    src_pool[0] = 32'h0;
    dst_pool[0] = 32'hFFFF_FFFF;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: default protocol, retransmission, ignore, query hit and miss
    add_item(tcpr_pkg::FUNC_QUERY, 8'h0, 32'h0, 32'h0, 32'h0);
    add_item(tcpr_pkg::FUNC_RECORD, 8'd6, 32'h0, 32'hFFFF_FFFF, 32'd100);
    add_item(tcpr_pkg::FUNC_RECORD, 8'd6, 32'h0, 32'hFFFF_FFFF, 32'd50);
    add_item(tcpr_pkg::FUNC_RECORD, 8'd6, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(tcpr_pkg::FUNC_RECORD, 8'd6, 32'h0, 32'hFFFF_FFFF, 32'h0);
    add_item(tcpr_pkg::FUNC_RECORD, 8'd17, 32'h0, 32'hFFFF_FFFF, 32'd7);
    add_item(tcpr_pkg::FUNC_RECORD, 8'hFF, 32'h1, 32'h2, 32'd7);
    add_item(tcpr_pkg::FUNC_QUERY, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(tcpr_pkg::FUNC_QUERY, 8'd6, 32'hFFFF_FFFF, 32'h0, 32'h0);
    // fill the table to overflow
    for (int i = 0; i < 17; i++)
      add_item(tcpr_pkg::FUNC_RECORD, 8'd6, 32'(i + 100), 32'hFFFF_FFFF, 32'(i));
    add_item(tcpr_pkg::FUNC_QUERY, 8'd0, 32'd115, 32'hFFFF_FFFF, 32'd0);
    wait_drained();

    // a fresh table is not possible without reset; keep using full table state
    write_protocol(8'h00);
    for (int i = 0; i < 150; i++) pending_items.push_back(rand_item($urandom_range(9) < 8));
    add_item(tcpr_pkg::FUNC_RECORD, 8'h00, 32'h0, 32'hFFFF_FFFF, 32'd3);
    add_item(tcpr_pkg::FUNC_QUERY, 8'h00, 32'h0, 32'hFFFF_FFFF, 32'd3);
    wait_drained();

    write_protocol(8'hFF);
    for (int i = 0; i < 250; i++) pending_items.push_back(rand_item($urandom_range(9) < 8));
    wait_drained();

    sender_idle_pct = 76;
    write_protocol(8'($urandom_range(1, 254)));
    for (int i = 0; i < 250; i++) pending_items.push_back(rand_item($urandom_range(9) < 8));
    wait_drained();

    sender_idle_pct = 0;
    write_protocol(8'd6);
    for (int i = 0; i < 280; i++) pending_items.push_back(rand_item($urandom_range(9) < 8));
    wait_drained();

    if (n_errors == 0) begin
      $display("tcp_retransmission_flow_table_top verification clean");
    end else begin
      $display("tcp_retransmission_flow_table_top verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tcp_retransmission_flow_table_top verification failed");
    $finish;
  end

endmodule
